// ===== sv/tgarle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; every other file of the block imports this package.
package tgarle_pkg;

   // Configuration register indexes and widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RLE_MODE        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_TOTAL     = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [2:0]  BPP_RESET         = 3'd4;
   localparam logic        RLE_MODE_RESET    = 1'b1;
   localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

   // Pixel size code that selects 3-byte pixels; anything else means 4.
   localparam logic [2:0] BPP_THREE = 3'd3;

   // Packet header layout: kind in bit 7, count minus one in the low bits.
   localparam int         HDR_KIND_BIT   = 7;
   localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;

   // Input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        image_done;
   } rsp_type;

   // One decoded byte passed from the front to the back through the queue.
   // The has_pixel flag marks a byte that completed a pixel.
   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  pixel_count;
      logic        has_pixel;
      logic        image_start;
   } cand_type;

endpackage

// ===== sv/tgarle_front.sv =====
`timescale 1ns / 1ps
// Front part: parses packet headers and gathers pixel bytes into candidates.
// Depends on tgarle_pkg.
module tgarle_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tgarle_pkg::req_type  req_data,
   input  logic [2:0]           cfg_bytes_per_pixel,
   input  logic                 cfg_rle_mode,
   output logic                 push_valid,
   output tgarle_pkg::cand_type push_data,
   input  logic                 push_ready
);
   import tgarle_pkg::*;

   logic        awaiting_header_ff, awaiting_header_in;
   logic        run_packet_ff, run_packet_in;
   logic [7:0]  pixels_left_ff, pixels_left_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [31:0] gather_ff, gather_in;

   logic        accept;
   logic        cur_awaiting, cur_run;
   logic [7:0]  cur_left;
   logic [1:0]  cur_bip, next_bip;
   logic [31:0] cur_gather, merged;
   logic        is_header, pixel_done, size_three;
   logic [7:0]  left_after;

   // A beat is taken whenever the queue has room; every beat becomes one queue entry,
   // so the back sees each byte and can tell when the image is already complete.
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign size_three = (cfg_bytes_per_pixel == BPP_THREE);

   // Decode the byte against state, with image start restoring the cleared state.
   always_comb begin
      cur_awaiting = req_data.image_start ? 1'b1  : awaiting_header_ff;
      cur_run      = req_data.image_start ? 1'b0  : run_packet_ff;
      cur_left     = req_data.image_start ? 8'd0  : pixels_left_ff;
      cur_bip      = req_data.image_start ? 2'd0  : byte_in_pixel_ff;
      cur_gather   = req_data.image_start ? 32'd0 : gather_ff;

      is_header  = cfg_rle_mode && (cur_awaiting || (cur_left == 8'd0));
      merged     = cur_gather | ({24'd0, req_data.data_byte} << {cur_bip, 3'b000});
      next_bip   = cur_bip + 2'd1;
      pixel_done = (next_bip == 2'd0) || (size_three && (next_bip == 2'd3));

      awaiting_header_in = cur_awaiting;
      run_packet_in      = cur_run;
      pixels_left_in     = cur_left;
      byte_in_pixel_in   = cur_bip;
      gather_in          = cur_gather;
      left_after         = cur_left;

      push_valid             = req_valid;
      push_data.pixel_value  = merged;
      push_data.pixel_count  = 8'd1;
      push_data.has_pixel    = 1'b0;
      push_data.image_start  = req_data.image_start;

      if (is_header) begin
         // New packet: kind and pixel count; any partial pixel is dropped.
         run_packet_in      = req_data.data_byte[HDR_KIND_BIT];
         pixels_left_in     = {1'b0, req_data.data_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
         awaiting_header_in = 1'b0;
         byte_in_pixel_in   = 2'd0;
         gather_in          = 32'd0;
      end else if (!pixel_done) begin
         byte_in_pixel_in = next_bip;
         gather_in        = merged;
      end else begin
         // Pixel complete: hand it to the back with its packet accounting.
         push_data.has_pixel = 1'b1;
         if (cfg_rle_mode) begin
            if (cur_run) begin
               push_data.pixel_count = cur_left;
               left_after            = 8'd0;
            end else begin
               left_after = cur_left - 8'd1;
            end
            pixels_left_in = left_after;
            if (left_after == 8'd0) begin
               awaiting_header_in = 1'b1;
            end
         end
         byte_in_pixel_in = 2'd0;
         gather_in        = 32'd0;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_header_ff <= 1'b1;
         run_packet_ff      <= 1'b0;
         pixels_left_ff     <= 8'd0;
         byte_in_pixel_ff   <= 2'd0;
         gather_ff          <= 32'd0;
      end else if (accept) begin
         awaiting_header_ff <= awaiting_header_in;
         run_packet_ff      <= run_packet_in;
         pixels_left_ff     <= pixels_left_in;
         byte_in_pixel_ff   <= byte_in_pixel_in;
         gather_ff          <= gather_in;
      end
   end

endmodule

// ===== sv/tgarle_queue.sv =====
`timescale 1ns / 1ps
// Short first-in first-out queue of candidate pixels between front and back.
// Depends on tgarle_pkg.
module tgarle_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tgarle_pkg::cand_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tgarle_pkg::cand_type pop_data
);
   import tgarle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cand_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/tgarle_back.sv =====
`timescale 1ns / 1ps
// Back part: counts emitted pixels, clamps runs and drives the result register.
// Depends on tgarle_pkg.
module tgarle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tgarle_pkg::cand_type pop_data,
   input  logic [31:0]          cfg_pixel_total,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tgarle_pkg::rsp_type  rsp_data
);
   import tgarle_pkg::*;

   logic [31:0] emitted_ff, emitted_in;
   logic        finished_ff, finished_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        take;
   logic [31:0] cur_emitted;
   logic        cur_finished;
   logic [32:0] remaining;
   logic        exhausted, reaches_end;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Clamp the pixel count against what is left of the image.
   always_comb begin
      cur_emitted  = pop_data.image_start ? 32'd0 : emitted_ff;
      cur_finished = pop_data.image_start ? 1'b0  : finished_ff;
      remaining    = {1'b0, cfg_pixel_total} - {1'b0, cur_emitted};
      exhausted    = cur_finished || remaining[32] || (remaining == 33'd0);
      reaches_end  = ({25'd0, pop_data.pixel_count} >= remaining);

      emitted_in   = emitted_ff;
      finished_in  = finished_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (take) begin
         if (exhausted) begin
            // Image already complete: the byte is dropped and the image stays finished.
            emitted_in  = cur_emitted;
            finished_in = 1'b1;
         end else if (pop_data.has_pixel) begin
            emitted_in   = reaches_end ? cfg_pixel_total : cur_emitted
                           + {24'd0, pop_data.pixel_count};
            finished_in  = reaches_end;
            rsp_valid_in = 1'b1;
            rsp_in.pixel_value  = pop_data.pixel_value;
            rsp_in.repeat_count = reaches_end ? remaining[7:0] : pop_data.pixel_count;
            rsp_in.image_done   = reaches_end;
         end else begin
            // Header or partial pixel byte: only an image start changes the count.
            emitted_in  = cur_emitted;
            finished_in = cur_finished;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff   <= 32'd0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emitted_ff   <= emitted_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== sv/tga_rle_pixel_decoder_top.sv =====
`timescale 1ns / 1ps
// TGA pixel decoder top level: one data byte per beat, at most one pixel per result beat.
// Throughput is one byte per cycle; the input stalls only when the queue is full behind a held result.
// A pixel goes through the queue entry, then the result register, after its last byte is accepted.
// Synchronous reset clears all decode state and loads the register defaults:
// 4 bytes per pixel, run-length mode, pixel total of 1. No clearing pass is needed.
// Depends on tgarle_pkg, tgarle_front, tgarle_queue and tgarle_back.
module tga_rle_pixel_decoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tgarle_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tgarle_pkg::rsp_type                 rsp_data,
   input  logic                                csr_write_en,
   input  logic [tgarle_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tgarle_pkg::*;

   logic [2:0]  bytes_per_pixel_ff;
   logic        rle_mode_ff;
   logic [31:0] pixel_total_ff;

   logic        push_valid, push_ready;
   cand_type    push_data;
   logic        pop_valid, pop_ready;
   cand_type    pop_data;

   // Configuration registers; writes to unused indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_pixel_ff <= BPP_RESET;
         rle_mode_ff        <= RLE_MODE_RESET;
         pixel_total_ff     <= PIXEL_TOTAL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bytes_per_pixel_ff <= csr_wdata[2:0];
            CSR_RLE_MODE:        rle_mode_ff        <= csr_wdata[0];
            CSR_PIXEL_TOTAL:     pixel_total_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Header parsing and byte gathering.
   tgarle_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .cfg_bytes_per_pixel (bytes_per_pixel_ff),
      .cfg_rle_mode        (rle_mode_ff),
      .push_valid          (push_valid),
      .push_data           (push_data),
      .push_ready          (push_ready)
   );

   // Candidate pixel queue.
   tgarle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Pixel counting and result output.
   tgarle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .cfg_pixel_total (pixel_total_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TGA run-length pixel decoder top level.
// Depends on tgarle_pkg and tga_rle_pixel_decoder_top; a scoreboard class predicts each pixel.
module tb;
   import tgarle_pkg::*;

   // Scoreboard: tracks the decoder's register and image state, predicts pixels
   // from accepted bytes and checks the pixels that come back, in order.
   class pixel_scoreboard;
      rsp_type     expected_pixels[$];
      int          errors;
      int          checked;
      logic [2:0]  bpp_cfg;
      logic        rle_cfg;
      logic [31:0] total_cfg;
      logic        want_header;
      logic        is_run;
      logic [7:0]  pkt_left;
      logic [1:0]  byte_idx;
      logic [31:0] gather;
      logic [31:0] emitted;
      logic        done_flag;

      function new();
         errors = 0;
         checked = 0;
         bpp_cfg = BPP_RESET;
         rle_cfg = RLE_MODE_RESET;
         total_cfg = PIXEL_TOTAL_RESET;
         clear_image();
      endfunction

      function void clear_image();
         want_header = 1'b1;
         is_run = 1'b0;
         pkt_left = '0;
         byte_idx = '0;
         gather = '0;
         emitted = '0;
         done_flag = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BYTES_PER_PIXEL: bpp_cfg = val[2:0];
            CSR_RLE_MODE:        rle_cfg = val[0];
            CSR_PIXEL_TOTAL:     total_cfg = val;
            default: ;
         endcase
      endfunction

      // Advance the decode state by one accepted byte; queue a pixel if one completes.
      function void note_byte(req_type beat);
         logic [2:0]  size;
         logic [31:0] remaining;
         logic [31:0] count;
         rsp_type     px;
         size = (bpp_cfg == BPP_THREE) ? 3'd3 : 3'd4;
         if (beat.image_start)
            clear_image();
         // A complete image (or an empty one) swallows everything until the next start.
         if (done_flag || emitted >= total_cfg) begin
            done_flag = 1'b1;
            return;
         end
         // Packet header in run-length mode.
         if (rle_cfg && (want_header || pkt_left == 8'd0)) begin
            is_run = beat.data_byte[HDR_KIND_BIT];
            pkt_left = {1'b0, beat.data_byte[6:0] & HDR_COUNT_MASK} + 8'd1;
            want_header = 1'b0;
            byte_idx = '0;
            gather = '0;
            return;
         end
         gather |= 32'(beat.data_byte) << (byte_idx * 8);
         byte_idx = byte_idx + 2'd1;
         if (byte_idx != 2'd0 && byte_idx < size)
            return;
         // Pixel complete: work out its repeat count, clamped to what is left.
         remaining = total_cfg - emitted;
         count = 32'd1;
         if (rle_cfg) begin
            if (is_run) begin
               count = {24'd0, pkt_left};
               if (count > remaining)
                  count = remaining;
               pkt_left = 8'd0;
            end else begin
               pkt_left = pkt_left - 8'd1;
            end
            if (pkt_left == 8'd0)
               want_header = 1'b1;
         end
         emitted += count;
         if (emitted >= total_cfg)
            done_flag = 1'b1;
         px.pixel_value = gather;
         px.repeat_count = count[7:0];
         px.image_done = done_flag;
         expected_pixels.push_back(px);
         byte_idx = '0;
         gather = '0;
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel beat: pixel_value %h repeat_count %0d image_done %0d",
                   got.pixel_value, got.repeat_count, got.image_done);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (got.pixel_value !== want.pixel_value) begin
            $error("pixel_value expected %h actual %h", want.pixel_value, got.pixel_value);
            errors++;
         end
         if (got.repeat_count !== want.repeat_count) begin
            $error("repeat_count expected %0d actual %0d", want.repeat_count, got.repeat_count);
            errors++;
         end
         if (got.image_done !== want.image_done) begin
            $error("image_done expected %0d actual %0d", want.image_done, got.image_done);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BYTES_PER_PIXEL;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   pixel_scoreboard board = new();
   int  burst_left = 0;
   int  sent = 0;
   int  settings = 0;
   bit  hold_ask = 1'b0;
   int  hold_left = 0;
   int  rx_cycle = 0;

   tga_rle_pixel_decoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case the decoder hangs.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: check each accepted beat, then pick the next ready value.
   // Stall patterns rotate in turn; a requested hold-off keeps ready low
   // long enough for the decoder to back up.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_pixel(rsp_data);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            case ((rx_cycle / 400) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ((rx_cycle % 5) == 0);
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
         rx_cycle++;
      end
   end

   // Offer one byte and wait for it to be taken. The sender runs in bursts
   // with random gaps; valid only drops at the start of a gap.
   task automatic send_byte(input logic [7:0] value, input logic start);
      int      gap;
      req_type beat;
      beat.data_byte = value;
      beat.image_start = start;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      board.note_byte(beat);
      burst_left--;
      sent++;
   endtask

   // Drain: wait for all pixels back, then for bytes still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg_beat(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
   endtask

   task automatic set_config(input logic [2:0] bpp, input logic rle, input logic [31:0] total);
      write_reg_beat(CSR_BYTES_PER_PIXEL, 32'(bpp));
      write_reg_beat(CSR_RLE_MODE, 32'(rle));
      write_reg_beat(CSR_PIXEL_TOTAL, total);
      csr_write_en <= 1'b0;
      settings++;
   endtask

   // Send one image's worth of mostly well-formed data under the current
   // settings, with the occasional truncated packet or early restart.
   task automatic send_image(input int budget, input bit fresh);
      int          size;
      int          n;
      int          k;
      int          pixels;
      int          nbytes;
      int          cnt;
      logic [63:0] px;
      bit          run;
      bit          start;
      size = (board.bpp_cfg == BPP_THREE) ? 3 : 4;
      start = fresh;
      n = 0;
      px = '0;
      while (n < budget && px < 64'(board.total_cfg)) begin
         if (board.rle_cfg) begin
            run = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            send_byte({run, 7'(cnt)}, start);
            start = 1'b0;
            pixels = run ? 1 : cnt + 1;
            px += 64'(cnt + 1);
            n++;
         end else begin
            pixels = 1;
            px += 64'd1;
         end
         nbytes = pixels * size;
         // Now and then a packet is cut short and the framing slips.
         if ($urandom_range(0, 19) == 0)
            nbytes = $urandom_range(0, nbytes - 1);
         for (k = 0; k < nbytes; k++) begin
            send_byte(8'($urandom_range(0, 255)), start);
            start = 1'b0;
         end
         n += nbytes;
         if ($urandom_range(0, 29) == 0)
            start = 1'b1;
      end
      // Trailing bytes, normally ignored once the image is complete.
      nbytes = $urandom_range(0, 3);
      for (k = 0; k < nbytes; k++) begin
         send_byte(8'($urandom_range(0, 255)), start);
         start = 1'b0;
      end
   endtask

   // Main sequence.
   initial begin
      int          spins;
      int          phase;
      int          target;
      int          images;
      logic [2:0]  bpp;
      logic        rle;
      logic [31:0] total;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a one-pixel raw packet, then a byte past the end.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h12, 1'b0);

      // Longest run, clamped to a five-pixel image, 3-byte pixels.
      settle();
      set_config(BPP_THREE, 1'b1, 32'd5);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h77, 1'b0);

      // Odd size code acts as 4; raw packet longer than the image.
      settle();
      set_config(3'd7, 1'b1, 32'd2);
      send_byte(8'h05, 1'b1);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h30, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hDC, 1'b0);
      send_byte(8'hBA, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'hEE, 1'b0);

      // Empty image: every byte is dropped.
      settle();
      set_config(3'd0, 1'b0, 32'd0);
      send_byte(8'h33, 1'b1);
      send_byte(8'hCC, 1'b0);

      // Pixel size changes halfway through a pixel; the gathered bytes stay.
      settle();
      set_config(BPP_THREE, 1'b0, 32'd10);
      send_byte(8'h11, 1'b1);
      send_byte(8'h22, 1'b0);
      settle();
      set_config(3'd4, 1'b0, 32'd10);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);

      // Back-pressure: receiver holds off while raw pixels keep coming.
      settle();
      set_config(BPP_THREE, 1'b0, 32'hFFFF_FFFF);
      hold_ask = 1'b1;
      send_image(200, 1'b1);

      // Random settings and images until at least 1500 bytes have been sent in the whole run.
      target = 1500;
      phase = 0;
      while (sent < target) begin
         settle();
         case ($urandom_range(0, 5))
            0: bpp = 3'($urandom_range(0, 7));
            1, 2: bpp = BPP_THREE;
            default: bpp = 3'd4;
         endcase
         rle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: total = 32'hFFFF_FFFF;
            1: total = $urandom();
            2: total = 32'd0;
            3, 4: total = $urandom_range(1, 3);
            default: total = $urandom_range(1, 60);
         endcase
         if (phase == 0)
            total = 32'hFFFF_FFFF;
         set_config(bpp, rle, total);
         images = $urandom_range(1, 3);
         for (int i = 0; i < images; i++)
            send_image(150, (i > 0) || ($urandom_range(0, 3) != 0));
         phase++;
      end

      // Wind down and look for stragglers.
      req_valid <= 1'b0;
      for (spins = 0; spins < 20000 && board.expected_pixels.size() != 0; spins++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.expected_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", board.expected_pixels.size());
         board.errors++;
      end

      $display("summary: %0d bytes offered over %0d register settings, %0d pixels checked",
               sent, settings, board.checked);
      if (board.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
